>>> design/slra_pkg.sv
// Shared types, constants and the search step function of the sphere lens remap core.
// No dependencies; every design file but slra_checker imports this package.
package slra_pkg;

    localparam int LENS_SIZE = 128;
    localparam int LENS_R    = LENS_SIZE / 2;
    localparam int ADDR_W    = 24;
    localparam int K_BITS    = 6;
    localparam int N_STAGES  = 10;

    localparam logic [11:0] ORIGIN_X_RST = 12'd16;
    localparam logic [11:0] ORIGIN_Y_RST = 12'd16;
    localparam logic [12:0] STRIDE_RST   = 13'd340;
    localparam logic [9:0]  ZOOM_RST     = 10'd40;

    typedef enum logic [1:0] {
        REG_ORIGIN_X    = 2'd0,
        REG_ORIGIN_Y    = 2'd1,
        REG_LINE_STRIDE = 2'd2,
        REG_VIEW_DIST   = 2'd3
    } slra_reg_t;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [12:0] line_stride;
        logic [9:0]  view_dist;
    } slra_cfg_t;

    typedef struct packed {
        logic [K_BITS-1:0]   am;
        logic [31:0]         tgt;
        logic [K_BITS-1:0]   acc;
        logic [2*K_BITS-1:0] acc2;
        logic                neg;
    } slra_lane_t;

    typedef struct packed {
        slra_lane_t        xl;
        slra_lane_t        yl;
        logic [20:0]       q;
        logic [ADDR_W-1:0] dest;
    } slra_item_t;

    function automatic slra_lane_t slra_step(slra_lane_t ln, logic [20:0] q, logic [2:0] sb);
        slra_lane_t          res;
        logic [K_BITS-1:0]   c;
        logic [2*K_BITS-1:0] c2;
        logic [32:0]         prod;
        res  = ln;
        c    = ln.acc | (K_BITS'(1) << sb);
        c2   = ln.acc2 + ({{K_BITS{1'b0}}, ln.acc} << (sb + 3'd1))
             + ((2*K_BITS)'(1) << {sb, 1'b0});
        prod = 33'({21'b0, c2} * {12'b0, q});
        if (prod < {1'b0, ln.tgt}) begin
            res.acc  = c;
            res.acc2 = c2;
        end
        return res;
    endfunction

endpackage

>>> design/slra_front.sv
// Front stages: quadrant offsets, circle test, destination address, radicand and targets.
// Depends on slra_pkg.
module slra_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [2:0]          en,
    input  logic                in_valid,
    input  logic [6:0]          lens_col,
    input  logic [6:0]          lens_row,
    input  slra_pkg::slra_cfg_t cfg,
    output logic [2:0]          vld,
    output slra_pkg::slra_item_t item
);
    import slra_pkg::*;

    logic [2:0]        vld_reg;
    logic [6:0]        ax_reg, ay_reg;
    logic              xneg_reg, yneg_reg, inside_reg;
    logic [ADDR_W-1:0] desta_reg;

    logic [5:0]        amx_reg, amy_reg;
    logic              xnegb_reg, ynegb_reg;
    logic [15:0]       adx_reg, ady_reg;
    logic [20:0]       q_reg;
    logic [ADDR_W-1:0] destb_reg;

    slra_item_t        item_reg;

    logic              xneg_next, yneg_next, inside_next;
    logic [6:0]        ax_next, ay_next;
    logic [14:0]       rsq;
    logic [12:0]       rowsum;
    logic [26:0]       daddr;
    logic [5:0]        amx_next, amy_next;
    logic [20:0]       q_next;

    always_comb begin
        xneg_next   = lens_col < 7'(LENS_R);
        yneg_next   = lens_row < 7'(LENS_R);
        ax_next     = xneg_next ? 7'(LENS_R) - lens_col : lens_col - 7'(LENS_R);
        ay_next     = yneg_next ? 7'(LENS_R) - lens_row : lens_row - 7'(LENS_R);
        rsq         = 15'({7'b0, ax_next} * {7'b0, ax_next})
                    + 15'({7'b0, ay_next} * {7'b0, ay_next});
        inside_next = rsq < 15'(LENS_R * LENS_R);
        rowsum      = {1'b0, cfg.origin_y} + {6'b0, lens_row};
        daddr       = 27'({13'b0, rowsum} * {13'b0, cfg.line_stride})
                    + {15'b0, cfg.origin_x} + {20'b0, lens_col};
        amx_next    = inside_reg ? ax_reg[5:0] : 6'd0;
        amy_next    = inside_reg ? ay_reg[5:0] : 6'd0;
        q_next      = 21'({10'b0, cfg.view_dist} * {10'b0, cfg.view_dist})
                    + 21'(LENS_R * LENS_R)
                    - 21'({6'b0, amx_next} * {6'b0, amx_next})
                    - 21'({6'b0, amy_next} * {6'b0, amy_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 3'b000;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid;
            if (en[1]) vld_reg[1] <= vld_reg[0];
            if (en[2]) vld_reg[2] <= vld_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ax_reg     <= ax_next;
            ay_reg     <= ay_next;
            xneg_reg   <= xneg_next;
            yneg_reg   <= yneg_next;
            inside_reg <= inside_next;
            desta_reg  <= daddr[ADDR_W-1:0];
        end
        if (en[1]) begin
            amx_reg   <= amx_next;
            amy_reg   <= amy_next;
            xnegb_reg <= xneg_reg;
            ynegb_reg <= yneg_reg;
            adx_reg   <= 16'({10'b0, amx_next} * {6'b0, cfg.view_dist});
            ady_reg   <= 16'({10'b0, amy_next} * {6'b0, cfg.view_dist});
            q_reg     <= q_next;
            destb_reg <= desta_reg;
        end
        if (en[2]) begin
            item_reg.xl.am   <= amx_reg;
            item_reg.xl.tgt  <= 32'({16'b0, adx_reg} * {16'b0, adx_reg});
            item_reg.xl.acc  <= '0;
            item_reg.xl.acc2 <= '0;
            item_reg.xl.neg  <= xnegb_reg;
            item_reg.yl.am   <= amy_reg;
            item_reg.yl.tgt  <= 32'({16'b0, ady_reg} * {16'b0, ady_reg});
            item_reg.yl.acc  <= '0;
            item_reg.yl.acc2 <= '0;
            item_reg.yl.neg  <= ynegb_reg;
            item_reg.q       <= q_reg;
            item_reg.dest    <= destb_reg;
        end
    end

    assign vld  = vld_reg;
    assign item = item_reg;

endmodule

>>> design/slra_search.sv
// One bit of the binary search for the shift magnitude, both axes side by side.
// Depends on slra_pkg.
module slra_search (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [2:0]           step_bit,
    input  logic                 in_valid,
    input  slra_pkg::slra_item_t in_item,
    output logic                 out_valid,
    output slra_pkg::slra_item_t out_item
);
    import slra_pkg::*;

    logic       vld_reg;
    slra_item_t item_reg;
    slra_item_t item_next;

    always_comb begin
        item_next    = in_item;
        item_next.xl = slra_step(in_item.xl, in_item.q, step_bit);
        item_next.yl = slra_step(in_item.yl, in_item.q, step_bit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) item_reg <= item_next;
    end

    assign out_valid = vld_reg;
    assign out_item  = item_reg;

endmodule

>>> design/slra_back.sv
// Output stage: signed shifts, pixel offset, source address and the output register.
// Depends on slra_pkg.
module slra_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  slra_pkg::slra_item_t in_item,
    input  logic [12:0]          line_stride,
    output logic                 out_valid,
    output logic [23:0]          dest_address,
    output logic [23:0]          source_address,
    output logic signed [23:0]   pixel_offset
);
    import slra_pkg::*;

    logic                      vld_reg;
    logic [ADDR_W-1:0]         dest_reg, src_reg;
    logic signed [ADDR_W-1:0]  off_reg;

    logic [K_BITS-1:0]         kx, ky, mx, my;
    logic signed [K_BITS:0]    sx, sy;
    logic signed [21:0]        prod;
    logic signed [ADDR_W-1:0]  off_next;

    always_comb begin
        kx   = (in_item.xl.tgt != 32'd0) ? in_item.xl.acc + K_BITS'(1) : '0;
        ky   = (in_item.yl.tgt != 32'd0) ? in_item.yl.acc + K_BITS'(1) : '0;
        mx   = in_item.xl.am - kx;
        my   = in_item.yl.am - ky;
        sx   = in_item.xl.neg ? $signed({1'b0, mx}) : -$signed({1'b0, mx});
        sy   = in_item.yl.neg ? $signed({1'b0, my}) : -$signed({1'b0, my});
        prod = 22'(sy * $signed({1'b0, line_stride}));
        off_next = ADDR_W'(prod) + ADDR_W'(sx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dest_reg <= in_item.dest;
            off_reg  <= off_next;
            src_reg  <= in_item.dest + off_next;
        end
    end

    assign out_valid      = vld_reg;
    assign dest_address   = dest_reg;
    assign source_address = src_reg;
    assign pixel_offset   = off_reg;

endmodule

>>> design/sphere_lens_remap_address_core.sv
// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_lens_col, s_lens_row
// m_        out        m_valid, m_ready, m_dest_address, m_source_address, m_pixel_offset
// cfg       in         cfg_wr_en, cfg_index, cfg_wdata
//
// Ten register stages: three front stages, six binary search steps, one output stage.
// One word is accepted per cycle while s_ready is high; each stage holds only while
// the one after it is full and stalled, so bubbles are squeezed out under backpressure.
// Reset clears the stage valid bits and loads the register defaults.
// Top level of the sphere lens remap address core; depends on slra_pkg and its submodules.
module sphere_lens_remap_address_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [6:0]         s_lens_col,
    input  logic [6:0]         s_lens_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_dest_address,
    output logic [23:0]        m_source_address,
    output logic signed [23:0] m_pixel_offset,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_wdata
);
    import slra_pkg::*;

    slra_cfg_t              cfg_reg;
    logic [N_STAGES-1:0]    vld;
    logic [N_STAGES-1:0]    en;
    slra_item_t             items [K_BITS+1];
    logic [K_BITS:0]        ivld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x    <= ORIGIN_X_RST;
            cfg_reg.origin_y    <= ORIGIN_Y_RST;
            cfg_reg.line_stride <= STRIDE_RST;
            cfg_reg.view_dist   <= ZOOM_RST;
        end else if (cfg_wr_en) begin
            case (slra_reg_t'(cfg_index))
                REG_ORIGIN_X:    cfg_reg.origin_x    <= cfg_wdata[11:0];
                REG_ORIGIN_Y:    cfg_reg.origin_y    <= cfg_wdata[11:0];
                REG_LINE_STRIDE: cfg_reg.line_stride <= cfg_wdata;
                REG_VIEW_DIST:   cfg_reg.view_dist   <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        en[N_STAGES-1] = !vld[N_STAGES-1] || m_ready;
        for (int i = N_STAGES - 2; i >= 0; i--) begin
            en[i] = !vld[i] || en[i+1];
        end
    end

    assign s_ready = en[0];

    slra_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en[2:0]),
        .in_valid (s_valid),
        .lens_col (s_lens_col),
        .lens_row (s_lens_row),
        .cfg      (cfg_reg),
        .vld      (vld[2:0]),
        .item     (items[0])
    );

    assign ivld[0] = vld[2];

    for (genvar g = 0; g < K_BITS; g++) begin : g_search
        slra_search u_search (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en[3+g]),
            .step_bit  (3'(K_BITS - 1 - g)),
            .in_valid  (ivld[g]),
            .in_item   (items[g]),
            .out_valid (ivld[g+1]),
            .out_item  (items[g+1])
        );
        assign vld[3+g] = ivld[g+1];
    end

    slra_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en[N_STAGES-1]),
        .in_valid       (ivld[K_BITS]),
        .in_item        (items[K_BITS]),
        .line_stride    (cfg_reg.line_stride),
        .out_valid      (vld[N_STAGES-1]),
        .dest_address   (m_dest_address),
        .source_address (m_source_address),
        .pixel_offset   (m_pixel_offset)
    );

    assign m_valid = vld[N_STAGES-1];

endmodule

>>> design/slra_checker.sv
// Port-level checks for the sphere lens remap core, bound to the top level.
// Depends on sphere_lens_remap_address_core.
module slra_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_dest_address,
    input logic [23:0] m_source_address,
    input logic [23:0] m_pixel_offset
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_ready_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    a_zero_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pixel_offset == 24'd0) |-> (m_source_address == m_dest_address))
        else $error("source differs from destination with zero offset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_dest_address)))
        else $error("stalled word changed");

endmodule

bind sphere_lens_remap_address_core slra_checker u_slra_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_dest_address   (m_dest_address),
    .m_source_address (m_source_address),
    .m_pixel_offset   (m_pixel_offset)
);

>>> bench/tb.sv
// Testbench for sphere_lens_remap_address_core: drives lens pixel positions under
// random burst and stall patterns, predicts addresses and offsets, checks each word.
// Depends on slra_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;
    import slra_pkg::*;

    typedef struct {
        logic [23:0] dest;
        logic [23:0] src;
        logic [23:0] ofs;
    } remap_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [6:0]  s_lens_col = '0;
    logic [6:0]  s_lens_row = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_dest_address;
    logic [23:0] m_source_address;
    logic signed [23:0] m_pixel_offset;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_wdata = '0;

    logic [11:0] org_x = ORIGIN_X_RST;
    logic [11:0] org_y = ORIGIN_Y_RST;
    logic [12:0] stride = STRIDE_RST;
    logic [9:0]  zoom = ZOOM_RST;

    remap_t pending_remaps[$];
    int     errors = 0;
    int     words_sent = 0;
    int     words_checked = 0;
    int     hold_cycles = 0;
    int     burst_left = 0;

    sphere_lens_remap_address_core DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint unsigned lens_shift(longint unsigned m, longint unsigned d,
                                                   longint unsigned q);
        longint unsigned goal;
        longint unsigned k;
        goal = (m * d) * (m * d);
        k = 0;
        while (k < m && k * k * q < goal) k++;
        return m - k;
    endfunction

    function automatic remap_t remap_of(logic [6:0] col, logic [6:0] row);
        remap_t          res;
        longint unsigned r, a, b, ixm, iym, xs, ys, q, ofs, dst;
        r = LENS_R;
        a = (col < r) ? r - col : col - r;
        b = (row < r) ? r - row : row - r;
        ixm = 0;
        iym = 0;
        if (a * a + b * b < r * r) begin
            q = zoom * zoom + r * r - a * a - b * b;
            ixm = lens_shift(a, zoom, q);
            iym = lens_shift(b, zoom, q);
        end
        xs = (col < r) ? ixm : -ixm;
        ys = (row < r) ? iym : -iym;
        if (col == r) xs = 0;
        if (row == r) ys = 0;
        ofs = ys * stride + xs;
        dst = (longint'(org_y) + row) * stride + org_x + col;
        res.dest = dst[23:0];
        res.src = dst[23:0] + ofs[23:0];
        res.ofs = ofs[23:0];
        return res;
    endfunction

    task automatic write_reg(slra_reg_t idx, logic [12:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ORIGIN_X:    org_x = val[11:0];
            REG_ORIGIN_Y:    org_y = val[11:0];
            REG_LINE_STRIDE: stride = val;
            REG_VIEW_DIST:   zoom = val[9:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_remaps.size() != 0) @(posedge aclk);
        repeat (15) @(posedge aclk);
    endtask

    task automatic set_lens(logic [11:0] x, logic [11:0] y, logic [12:0] s, logic [9:0] z);
        drain();
        write_reg(REG_ORIGIN_X, {1'b0, x});
        write_reg(REG_ORIGIN_Y, {1'b0, y});
        write_reg(REG_LINE_STRIDE, s);
        write_reg(REG_VIEW_DIST, {3'b0, z});
    endtask

    // send one word; gaps come between random bursts unless told otherwise
    task automatic send_pixel(logic [6:0] col, logic [6:0] row, bit gaps = 1);
        int gap;
        if (gaps && burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_lens_col <= col;
        s_lens_row <= row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_remaps.push_back(remap_of(col, row));
        words_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    task automatic test_directed();
        logic [6:0] edges[6] = '{0, 1, 63, 64, 65, 127};
        foreach (edges[i]) send_pixel(edges[i], edges[5 - i]);
        send_pixel(64, 64);
        send_pixel(40, 50);
        send_pixel(90, 30);
        send_pixel(100, 100);
        send_pixel(127, 127);
        send_pixel(85, 64);
        send_pixel(64, 20);
        send_pixel(7'h55, 7'h2a);
        send_pixel(7'h2a, 7'h55);
    endtask

    task automatic test_random(int count);
        int i;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) != 0)
                send_pixel(7'($urandom_range(10, 118)), 7'($urandom_range(10, 118)));
            else
                send_pixel(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 60;
        repeat (40) send_pixel(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 0);
        drain();
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (($urandom_range(0, 255) >> (words_checked[8:7])) % 4) != 0;
        end
    end

    always @(posedge aclk) begin
        remap_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_remaps.size() == 0) begin
                $error("unexpected word: dest %h", m_dest_address);
                errors++;
            end else begin
                exp = pending_remaps.pop_front();
                if (m_dest_address !== exp.dest) begin
                    $error("dest_address exp %h got %h", exp.dest, m_dest_address);
                    errors++;
                end
                if (m_source_address !== exp.src) begin
                    $error("source_address exp %h got %h", exp.src, m_source_address);
                    errors++;
                end
                if (m_pixel_offset !== exp.ofs) begin
                    $error("pixel_offset exp %h got %h", exp.ofs, m_pixel_offset);
                    errors++;
                end
            end
            words_checked++;
        end
    end

    initial begin
        int w;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        set_lens(12'd0, 12'd0, 13'd0, 10'd0);
        test_directed();
        set_lens(12'hfff, 12'hfff, 13'h1fff, 10'h3ff);
        test_directed();
        set_lens(12'd100, 12'd3000, 13'd4096, 10'd1);
        test_random(200);
        test_backpressure();
        set_lens(12'haaa, 12'h555, 13'h0aaa, 10'h155);
        test_random(200);
        set_lens(12'h555, 12'haaa, 13'h1555, 10'h2aa);
        test_random(200);
        test_backpressure();
        for (w = 0; w < 3; w++) begin
            set_lens(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                     13'($urandom_range(0, 8191)), 10'($urandom_range(0, 1023)));
            test_random(100);
        end
        drain();
        $display("covered %0d pixel words over 9 lens settings including zero and full-scale",
                 words_sent);
        $display("registers, with two long output stalls; %0d words checked", words_checked);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
